// ===== hdl/cps_pkg.sv =====
// shared types, constants and helpers for the counter priority task scheduler
// no dependencies
`default_nettype none
package cps_pkg;
    localparam int TASKS = 64;
    localparam int SLOT_BITS = 6;
    localparam int POS_BITS = $clog2(TASKS);
    localparam int COUNT_BITS = 10;
    localparam int PRIO_BITS = 8;
    localparam int HOLD_BITS = 4;
    localparam int SUM_BITS = COUNT_BITS + PRIO_BITS + 1;

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

    typedef enum logic [2:0] {
        KIND_LOAD    = 3'd0,
        KIND_SET_RUN = 3'd1,
        KIND_TICK    = 3'd2,
        KIND_YIELD   = 3'd3,
        KIND_DISABLE = 3'd4,
        KIND_ENABLE  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK,
        ST_PASS,
        ST_RECHARGE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic                         valid;
        logic                         running;
        logic [PRIO_BITS-1:0]         prio;
        logic signed [COUNT_BITS-1:0] count;
        logic [HOLD_BITS-1:0]         hold;
        logic [SLOT_BITS-1:0]         tag;
    } entry_t;

    // floor(count/2) + prio, saturated at the top
    function automatic logic signed [COUNT_BITS-1:0] recharge(
        input logic signed [COUNT_BITS-1:0] count,
        input logic [PRIO_BITS-1:0] prio
    );
        logic signed [SUM_BITS-1:0] sum;
        sum = SUM_BITS'(count >>> 1) + SUM_BITS'($signed({1'b0, prio}));
        if (sum > SUM_BITS'(CNT_MAX))
            return CNT_MAX;
        else
            return sum[COUNT_BITS-1:0];
    endfunction

    function automatic logic signed [COUNT_BITS-1:0] dec_sat(
        input logic signed [COUNT_BITS-1:0] count
    );
        if (count == CNT_MIN)
            return CNT_MIN;
        else
            return count - COUNT_BITS'(1);
    endfunction
endpackage
`default_nettype wire

// ===== hdl/counter_priority_task_scheduler.sv =====
// top level of the counter priority task scheduler: ring of task cells plus control
// depends on cps_pkg and cps_cell
//
// channel   direction  signals                                       transfer
// command   in         kind slot prio_value run_flag                 start && !busy
// result    out        current_slot switched previous_slot           done (one cycle)
//                      current_count
//
// the task table is a ring of TASKS cells that rotates one slot per cycle while a command seeks or passes
// a command first rotates until its slot (or the current slot) leaves the ring
// a reschedule adds one full rotation, and a recharge one more
// unknown kinds go straight to the result; the result strobe cannot be stalled
// reset loads slot 0 as valid and running with priority 1, every other cell empty
`default_nettype none
module counter_priority_task_scheduler (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [2:0]                       kind,
    input  wire  [5:0]                       slot,
    input  wire  [7:0]                       prio_value,
    input  wire                              run_flag,
    output logic                             done,
    output logic [5:0]                       current_slot,
    output logic                             switched,
    output logic [5:0]                       previous_slot,
    output logic signed [9:0]                current_count
);
    import cps_pkg::*;

    // ring of cells, head is the last cell, feed enters cell 0
    entry_t cell_q [TASKS];
    entry_t head;
    entry_t feed;
    logic   shift;

    genvar gi;
    generate
        for (gi = 0; gi < TASKS; gi++)
        begin : g_ring
            entry_t init_val;
            assign init_val.valid   = (gi == 0);
            assign init_val.running = (gi == 0);
            assign init_val.prio    = (gi == 0) ? PRIO_BITS'(1) : '0;
            assign init_val.count   = '0;
            assign init_val.hold    = '0;
            assign init_val.tag     = SLOT_BITS'(gi);
            cps_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .init  (init_val),
                .din   ((gi == 0) ? feed : cell_q[(gi == 0) ? 0 : gi - 1]),
                .dout  (cell_q[gi])
            );
        end
    endgenerate

    assign head = cell_q[TASKS-1];

    // control registers
    state_t                       state_reg, state_next;
    kind_t                        kind_reg, kind_next;
    logic [SLOT_BITS-1:0]         target_reg, target_next;
    logic [PRIO_BITS-1:0]         prio_reg, prio_next;
    logic                         flag_reg, flag_next;
    logic [SLOT_BITS-1:0]         run_slot_reg, run_slot_next;
    logic [SLOT_BITS-1:0]         prev_reg, prev_next;
    logic signed [COUNT_BITS-1:0] shadow_reg, shadow_next;
    logic [POS_BITS-1:0]          pos_reg, pos_next;
    // search over the rotating entries
    logic                         found_reg, found_next;
    logic signed [COUNT_BITS-1:0] best_reg, best_next;
    logic [SLOT_BITS-1:0]         sel_reg, sel_next;
    logic signed [COUNT_BITS-1:0] zero_cnt_reg, zero_cnt_next;

    logic                         take;
    logic signed [COUNT_BITS-1:0] dec_val;
    logic                         last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            kind_reg     <= KIND_LOAD;
            target_reg   <= '0;
            prio_reg     <= '0;
            flag_reg     <= 1'b0;
            run_slot_reg <= '0;
            prev_reg     <= '0;
            shadow_reg   <= '0;
            pos_reg      <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            sel_reg      <= '0;
            zero_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            target_reg   <= target_next;
            prio_reg     <= prio_next;
            flag_reg     <= flag_next;
            run_slot_reg <= run_slot_next;
            prev_reg     <= prev_next;
            shadow_reg   <= shadow_next;
            pos_reg      <= pos_next;
            found_reg    <= found_next;
            best_reg     <= best_next;
            sel_reg      <= sel_next;
            zero_cnt_reg <= zero_cnt_next;
        end
    end

    assign dec_val = dec_sat(head.count);
    assign last    = (pos_reg == POS_BITS'(TASKS - 1));

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        target_next   = target_reg;
        prio_next     = prio_reg;
        flag_next     = flag_reg;
        run_slot_next = run_slot_reg;
        prev_next     = prev_reg;
        shadow_next   = shadow_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        sel_next      = sel_reg;
        zero_cnt_next = zero_cnt_reg;
        feed          = head;
        shift         = 1'b0;
        take          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    prev_next = run_slot_reg;
                    prio_next = prio_value;
                    flag_next = run_flag;
                    kind_next = kind_t'(kind);
                    case (kind_t'(kind))
                        KIND_LOAD, KIND_SET_RUN:
                        begin
                            target_next = slot;
                            state_next  = ({1'b0, slot} < (SLOT_BITS + 1)'(TASKS))
                                          ? ST_SEEK : ST_REPORT;
                        end
                        KIND_TICK, KIND_YIELD, KIND_DISABLE, KIND_ENABLE:
                        begin
                            target_next = run_slot_reg;
                            state_next  = ST_SEEK;
                        end
                        default:
                        begin
                            state_next = ST_REPORT;
                        end
                    endcase
                end
            end

            ST_SEEK:
            begin
                shift = 1'b1;
                if (head.tag == target_reg)
                begin
                    state_next = ST_REPORT;
                    case (kind_reg)
                        KIND_LOAD:
                        begin
                            feed.valid   = 1'b1;
                            feed.running = flag_reg;
                            feed.prio    = prio_reg;
                            feed.count   = (COUNT_BITS'($signed({1'b0, prio_reg})) > CNT_MAX
                                            || COUNT_BITS < PRIO_BITS + 1)
                                           && ({1'b0, prio_reg} > (PRIO_BITS + 1)'(CNT_MAX))
                                           ? CNT_MAX : COUNT_BITS'(prio_reg);
                            feed.hold    = '0;
                        end
                        KIND_SET_RUN:
                        begin
                            feed.running = flag_reg;
                        end
                        KIND_TICK:
                        begin
                            if (dec_val > 0 || head.hold != '0)
                            begin
                                feed.count = dec_val;
                            end
                            else
                            begin
                                feed.count = '0;
                                state_next = ST_PASS;
                            end
                        end
                        KIND_YIELD:
                        begin
                            feed.count = '0;
                            state_next = ST_PASS;
                        end
                        KIND_DISABLE:
                        begin
                            if (head.hold != HOLD_MAX)
                                feed.hold = head.hold + HOLD_BITS'(1);
                        end
                        KIND_ENABLE:
                        begin
                            if (head.hold != '0)
                                feed.hold = head.hold - HOLD_BITS'(1);
                        end
                        default:
                        begin
                            feed = head;
                        end
                    endcase
                    if (head.tag == run_slot_reg)
                        shadow_next = feed.count;
                    pos_next   = '0;
                    found_next = 1'b0;
                    best_next  = '0;
                    sel_next   = '0;
                end
            end

            ST_PASS, ST_RECHARGE:
            begin
                shift = 1'b1;
                if (state_reg == ST_RECHARGE && head.valid)
                    feed.count = recharge(head.count, head.prio);
                // running task with the largest counter, ties to the lowest slot
                take = feed.valid && feed.running && feed.count >= 0 &&
                       (!found_reg || feed.count > best_reg ||
                        (feed.count == best_reg && feed.tag < sel_reg));
                if (take)
                begin
                    found_next = 1'b1;
                    best_next  = feed.count;
                    sel_next   = feed.tag;
                end
                if (feed.tag == '0)
                    zero_cnt_next = feed.count;
                pos_next = pos_reg + POS_BITS'(1);
                if (last)
                begin
                    pos_next = '0;
                    if (state_reg == ST_PASS && found_next && best_next == '0)
                    begin
                        state_next = ST_RECHARGE;
                        found_next = 1'b0;
                        best_next  = '0;
                        sel_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_REPORT;
                        if (found_next)
                        begin
                            run_slot_next = sel_next;
                            shadow_next   = best_next;
                        end
                        else
                        begin
                            run_slot_next = '0;
                            shadow_next   = zero_cnt_next;
                        end
                    end
                end
            end

            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = (state_reg == ST_REPORT);
    assign current_slot  = run_slot_reg;
    assign previous_slot = prev_reg;
    assign switched      = (run_slot_reg != prev_reg);
    assign current_count = shadow_reg;

`ifndef SYNTHESIS
    // the result strobe only shows while a command is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result strobe outside a command");
    // a result frees the block for the next command
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("block still busy after result");
    // an accepted command always occupies the block
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("command transfer lost");
    // the current slot only changes on the result cycle
    a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> $stable(current_slot) || done) else $error("current slot moved while idle");
`endif
endmodule
`default_nettype wire

// ===== hdl/cps_cell.sv =====
// one task table cell of the rotating ring
// depends on cps_pkg
`default_nettype none
module cps_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  shift,
    input  cps_pkg::entry_t      init,
    input  cps_pkg::entry_t      din,
    output cps_pkg::entry_t      dout
);
    import cps_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= init;
        end
        else if (shift)
        begin
            entry_reg <= din;
        end
    end

    assign dout = entry_reg;
endmodule
`default_nettype wire
